// ----- rtl/ntt_pkg.sv -----
// Package for the note string to tone block: field widths, codes, state types,
// the octave 4 period tables and the controller command and status structs.
// No dependencies; every other file of the block imports it.
`default_nettype none

package ntt_pkg;

  localparam int KIND_W   = 2;
  localparam int CHAR_W   = 8;
  localparam int PERIOD_W = 17;
  localparam int MS_W     = 16;
  localparam int OFF_W    = 4;
  localparam int BPM_W    = 10;
  localparam int TPB_W    = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 10;
  localparam int BASE_W   = 12;
  localparam int PROD_W   = 24;

  localparam logic [MS_W-1:0]   MS_PER_MINUTE = 16'd60000;
  localparam logic [OFF_W-1:0]  GAP_MS        = 4'd10;
  localparam logic [BPM_W-1:0]  BPM_RESET     = 10'd120;
  localparam logic [TPB_W-1:0]  TPB_RESET     = 8'd4;
  localparam logic [3:0]        OCTAVE_RESET  = 4'd4;
  localparam logic [7:0]        DUR_RESET     = 8'd4;

  localparam logic [CHAR_W-1:0] CHAR_SHARP = 8'h23;
  localparam logic [CHAR_W-1:0] CHAR_FLAT  = 8'h62;
  localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3a;

  // Letter codes are the low five bits of the ASCII letter.
  localparam logic [4:0] NOTE_A = 5'd1;
  localparam logic [4:0] NOTE_B = 5'd2;
  localparam logic [4:0] NOTE_E = 5'd5;
  localparam logic [4:0] NOTE_G = 5'd7;

  typedef enum logic [KIND_W-1:0] {
    KIND_NOTE  = 2'd0,
    KIND_BEAT  = 2'd1,
    KIND_START = 2'd2
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BPM = 2'd0,
    CFG_TPB = 2'd1
  } cfg_index_t;

  typedef enum logic [2:0] {
    PH_LETTER       = 3'd0,
    PH_AFTER_LETTER = 3'd1,
    PH_AFTER_ACC    = 3'd2,
    PH_AFTER_OCT    = 3'd3,
    PH_DUR1         = 3'd4,
    PH_DUR2         = 3'd5,
    PH_DONE         = 3'd6
  } parse_phase_t;

  typedef enum logic [2:0] {
    S_BEAT_START,
    S_BEAT_WAIT,
    S_TICK_START,
    S_TICK_WAIT,
    S_IDLE,
    S_CALC,
    S_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic take;       // an input item transfers this cycle
    logic div_start;  // launch the shared divider
    logic div_sel;    // 0: ms per beat, 1: ms per tick
    logic load_note;  // load the result register from the parsed note
    logic load_beat;  // load the result register with a beat of silence
  } ntt_cmd_t;

  typedef struct packed {
    logic div_done;
  } ntt_status_t;

  function automatic logic [BASE_W-1:0] plain_period(input logic [2:0] idx);
    logic [BASE_W-1:0] p;
    case (idx)
      3'd0:    p = 12'd2273;
      3'd1:    p = 12'd2025;
      3'd2:    p = 12'd3822;
      3'd3:    p = 12'd3405;
      3'd4:    p = 12'd3034;
      3'd5:    p = 12'd2863;
      3'd6:    p = 12'd2551;
      default: p = '0;
    endcase
    return p;
  endfunction

  function automatic logic [BASE_W-1:0] sharp_period(input logic [2:0] idx);
    logic [BASE_W-1:0] p;
    case (idx)
      3'd0:    p = 12'd2145;
      3'd2:    p = 12'd3608;
      3'd3:    p = 12'd3214;
      3'd5:    p = 12'd2703;
      3'd6:    p = 12'd2408;
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/ntt_if.sv -----
// Valid/ready channel interfaces of the note string to tone block.
// Depends on ntt_pkg for the payload widths.
`default_nettype none

interface ntt_note_if import ntt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [CHAR_W-1:0] char_req;
  logic              last;

  modport source (output valid, kind, char_req, last, input ready);
  modport sink   (input valid, kind, char_req, last, output ready);
endinterface

interface ntt_tone_if import ntt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                sound_on;
  logic [PERIOD_W-1:0] period_us;
  logic [MS_W-1:0]     on_ms;
  logic [OFF_W-1:0]    off_ms;

  modport source (output valid, sound_on, period_us, on_ms, off_ms, input ready);
  modport sink   (input valid, sound_on, period_us, on_ms, off_ms, output ready);
endinterface

interface ntt_cfg_if import ntt_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/ntt_div.sv -----
// Restoring divider, one quotient bit per cycle, for the tempo quotients.
// Depends on ntt_pkg for widths.
`default_nettype none

module ntt_div import ntt_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [MS_W-1:0]  dividend,
  input  wire logic [BPM_W-1:0] divisor,
  output logic [MS_W-1:0]       quotient,
  output logic                  done
);

  localparam int CNT_W = $clog2(MS_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [BPM_W-1:0] dvsr;
  logic [BPM_W-1:0] rem;
  logic [BPM_W:0]   trial;
  logic [BPM_W:0]   diff;
  logic             ge;

  assign trial = {rem, quotient[MS_W-1]};
  assign diff  = trial - {1'b0, dvsr};
  assign ge    = trial >= {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(MS_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The quotient shifts in over the dividend, so it holds the dividend at start.
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      dvsr     <= divisor;
      rem      <= '0;
    end else if (busy) begin
      quotient <= {quotient[MS_W-2:0], ge};
      rem      <= ge ? diff[BPM_W-1:0] : trial[BPM_W-1:0];
    end
  end

`ifndef SYNTH
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("divider done without a running division");
  a_start_runs: assert property (@(posedge clk) disable iff (rst)
    start |=> busy && !done)
    else $error("divider did not start");
`endif

endmodule

`default_nettype wire

// ----- rtl/ntt_ctrl.sv -----
// Controller of the note string to tone block: sequences the tempo divisions,
// item transfers, the note calculation cycle and the result hand-off.
// Depends on ntt_pkg for the state type and the command and status structs.
`default_nettype none

module ntt_ctrl import ntt_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic [KIND_W-1:0] kind,
  input  wire logic              last,
  input  wire logic              out_ready,
  input  wire logic              cfg_write,
  input  wire ntt_status_t       status,
  output logic                   in_ready,
  output logic                   out_valid,
  output ntt_cmd_t               cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_BEAT_START;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_BEAT_START: state_next = S_BEAT_WAIT;
      S_BEAT_WAIT:  if (status.div_done) state_next = S_TICK_START;
      S_TICK_START: state_next = S_TICK_WAIT;
      S_TICK_WAIT:  if (status.div_done) state_next = S_IDLE;
      S_IDLE: begin
        if (in_valid) begin
          if (kind == KIND_NOTE && last) state_next = S_CALC;
          else if (kind == KIND_BEAT)    state_next = S_OUT;
        end
      end
      S_CALC: state_next = S_OUT;
      S_OUT:  if (out_ready) state_next = S_IDLE;
      default: state_next = S_BEAT_START;
    endcase
    // A new tempo or tick count invalidates both quotients.
    if (cfg_write) state_next = S_BEAT_START;
  end

  always_comb begin
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    cmd           = '0;
    unique case (state)
      S_BEAT_START: cmd.div_start = 1'b1;
      S_BEAT_WAIT:  cmd.div_sel = 1'b0;
      S_TICK_START: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = 1'b1;
      end
      S_TICK_WAIT:  cmd.div_sel = 1'b1;
      S_IDLE: begin
        in_ready      = 1'b1;
        cmd.take      = in_valid;
        cmd.load_beat = in_valid && kind == KIND_BEAT;
      end
      S_CALC: cmd.load_note = 1'b1;
      S_OUT:  out_valid = 1'b1;
      default: ;
    endcase
  end

`ifndef SYNTH
  a_ready_xor_result: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input ready while a result is pending");
  a_calc_to_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_CALC && !cfg_write) |=> out_valid)
    else $error("note calculation did not present a result");
  a_last_char_calc: assert property (@(posedge clk) disable iff (rst)
    (cmd.take && kind == KIND_NOTE && last && !cfg_write) |=> state == S_CALC)
    else $error("last character did not start the note calculation");
`endif

endmodule

`default_nettype wire

// ----- rtl/ntt_dp.sv -----
// Datapath of the note string to tone block: tempo registers and quotients,
// the note string parser, the period and tone time logic and the result register.
// Depends on ntt_pkg and on ntt_div.
`default_nettype none

module ntt_dp import ntt_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire ntt_cmd_t              cmd,
  output ntt_status_t                status,
  input  wire logic [KIND_W-1:0]     kind,
  input  wire logic [CHAR_W-1:0]     char_req,
  input  wire logic                  last,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output logic                       sound_on,
  output logic [PERIOD_W-1:0]        period_us,
  output logic [MS_W-1:0]            on_ms,
  output logic [OFF_W-1:0]           off_ms
);

  // Tempo registers and the quotients derived from them.
  logic [BPM_W-1:0] bpm;
  logic [TPB_W-1:0] tpb;
  logic [BPM_W-1:0] bpm_eff;
  logic [TPB_W-1:0] tpb_eff;
  logic [MS_W-1:0]  ms_per_beat;
  logic [MS_W-1:0]  tick_ms;
  logic [MS_W-1:0]  div_dividend;
  logic [BPM_W-1:0] div_divisor;
  logic [MS_W-1:0]  div_quotient;
  logic             div_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      bpm <= BPM_RESET;
      tpb <= TPB_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_BPM: bpm <= cfg_data[BPM_W-1:0];
        CFG_TPB: tpb <= cfg_data[TPB_W-1:0];
        default: ;
      endcase
    end
  end

  assign bpm_eff      = (bpm == '0) ? BPM_W'(1) : bpm;
  assign tpb_eff      = (tpb == '0) ? TPB_W'(1) : tpb;
  assign div_dividend = cmd.div_sel ? ms_per_beat : MS_PER_MINUTE;
  assign div_divisor  = cmd.div_sel ? {{(BPM_W-TPB_W){1'b0}}, tpb_eff} : bpm_eff;

  ntt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quotient),
    .done     (div_done)
  );

  assign status.div_done = div_done;

  always_ff @(posedge clk) begin
    if (div_done) begin
      if (cmd.div_sel) tick_ms <= div_quotient;
      else             ms_per_beat <= div_quotient;
    end
  end

  // Parser state.
  parse_phase_t phase;
  logic [4:0]   note_code;
  logic         accidental;
  logic         octave_down;
  logic [3:0]   sticky_oct;
  logic [7:0]   sticky_dur;

  parse_phase_t phase_p;
  logic [4:0]   note_code_p;
  logic         accidental_p;
  logic         octave_down_p;
  logic [3:0]   sticky_oct_p;
  logic [7:0]   sticky_dur_p;
  logic [4:0]   flat_code;
  logic         letter_ok;

  assign letter_ok = note_code >= NOTE_A && note_code <= NOTE_G;
  assign flat_code = (note_code == NOTE_A) ? NOTE_G : note_code - 5'd1;

  always_comb begin
    phase_p       = phase;
    note_code_p   = note_code;
    accidental_p  = accidental;
    octave_down_p = octave_down;
    sticky_oct_p  = sticky_oct;
    sticky_dur_p  = sticky_dur;
    unique case (phase)
      PH_LETTER: begin
        note_code_p   = char_req[4:0];
        accidental_p  = 1'b0;
        octave_down_p = 1'b0;
        phase_p       = PH_AFTER_LETTER;
      end
      PH_AFTER_LETTER, PH_AFTER_ACC: begin
        if (phase == PH_AFTER_LETTER && (char_req == CHAR_SHARP || char_req == CHAR_FLAT)) begin
          if (letter_ok) begin
            accidental_p = 1'b1;
            if (char_req == CHAR_FLAT) begin
              // A flat is the sharp of the letter below; Cb and Fb have no sharp.
              note_code_p   = flat_code;
              octave_down_p = flat_code == NOTE_B;
              accidental_p  = !(flat_code == NOTE_B || flat_code == NOTE_E);
            end
          end
          phase_p = PH_AFTER_ACC;
        end else if (char_req == CHAR_COLON) begin
          phase_p = PH_DUR1;
        end else begin
          sticky_oct_p = char_req[3:0];
          phase_p      = PH_AFTER_OCT;
        end
      end
      PH_AFTER_OCT: phase_p = (char_req == CHAR_COLON) ? PH_DUR1 : PH_DONE;
      PH_DUR1: begin
        sticky_dur_p = {4'b0, char_req[3:0]};
        phase_p      = PH_DUR2;
      end
      PH_DUR2: begin
        sticky_dur_p = {sticky_dur[4:0], 3'b0} + {sticky_dur[6:0], 1'b0}
                     + {4'b0, char_req[3:0]};
        phase_p      = PH_DONE;
      end
      default: phase_p = PH_DONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_LETTER;
      note_code   <= '0;
      accidental  <= 1'b0;
      octave_down <= 1'b0;
      sticky_oct  <= OCTAVE_RESET;
      sticky_dur  <= DUR_RESET;
    end else if (cmd.take) begin
      case (kind)
        KIND_NOTE: begin
          note_code   <= note_code_p;
          accidental  <= accidental_p;
          octave_down <= octave_down_p;
          sticky_oct  <= sticky_oct_p;
          sticky_dur  <= sticky_dur_p;
          phase       <= last ? PH_LETTER : phase_p;
        end
        KIND_BEAT: phase <= PH_LETTER;
        KIND_START: begin
          phase      <= PH_LETTER;
          sticky_oct <= OCTAVE_RESET;
          sticky_dur <= DUR_RESET;
        end
        default: ;
      endcase
    end
  end

  // Period: octave 4 table value shifted by the octave offset.
  logic [2:0]          idx;
  logic [BASE_W-1:0]   base;
  logic [PERIOD_W-1:0] base_w;
  logic signed [5:0]   shift;
  logic [5:0]          shift_neg;
  logic [PERIOD_W-1:0] period;

  assign idx       = note_code[2:0] - 3'd1;
  assign base      = accidental ? sharp_period(idx) : plain_period(idx);
  assign base_w    = {{(PERIOD_W-BASE_W){1'b0}}, base};
  assign shift     = signed'({2'b00, sticky_oct}) - signed'({5'b0, octave_down}) - 6'sd4;
  assign shift_neg = 6'(-shift);
  assign period    = (shift >= 0) ? (base_w >> shift[3:0]) : (base_w << shift_neg[2:0]);

  // Tone time: ticks times ms per tick less the gap, kept within 0 to 60000.
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] prod_gap;
  logic [MS_W-1:0]   tone_ms;

  assign prod     = {8'b0, tick_ms} * {16'b0, sticky_dur};
  assign prod_gap = prod - {20'b0, GAP_MS};

  always_comb begin
    if (prod <= {20'b0, GAP_MS})               tone_ms = '0;
    else if (prod_gap > {8'b0, MS_PER_MINUTE}) tone_ms = MS_PER_MINUTE;
    else                                       tone_ms = prod_gap[MS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_note) begin
      sound_on  <= letter_ok;
      period_us <= letter_ok ? period : '0;
      on_ms     <= tone_ms;
      off_ms    <= GAP_MS;
    end else if (cmd.load_beat) begin
      sound_on  <= 1'b0;
      period_us <= '0;
      on_ms     <= ms_per_beat;
      off_ms    <= '0;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/note_string_to_tone.sv -----
// Note string to tone: top level joining the controller and the datapath.
// Depends on ntt_pkg, the channel interfaces, ntt_ctrl and ntt_dp.
`default_nettype none

// The block reads a note string one character per transfer and, on the
// character marked last, presents one result with the tone period, tone time
// and trailing gap; an empty item presents one beat of silence at once.
// A character that ends no note leaves the block ready for the next item. A
// last character goes through transfer, calculation and result, a beat rest
// through transfer and result; a result waits to be taken, and no item is
// taken while one is pending. After reset and every configuration write the
// block divides 60000 by the tempo and then by the tick count in one shared
// bit-serial divider (launch, 16 quotient bits, done) and takes no item
// until both quotients are done. The configuration channel is always ready.
module note_string_to_tone import ntt_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  ntt_note_if.sink   note,
  ntt_tone_if.source tone,
  ntt_cfg_if.sink    cfg
);

  ntt_cmd_t    cmd;
  ntt_status_t status;
  logic        cfg_write;

  assign cfg.ready = 1'b1;
  assign cfg_write = cfg.valid && cfg.ready;

  ntt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (note.valid),
    .kind      (note.kind),
    .last      (note.last),
    .out_ready (tone.ready),
    .cfg_write (cfg_write),
    .status    (status),
    .in_ready  (note.ready),
    .out_valid (tone.valid),
    .cmd       (cmd)
  );

  ntt_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .kind      (note.kind),
    .char_req  (note.char_req),
    .last      (note.last),
    .cfg_write (cfg_write),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .sound_on  (tone.sound_on),
    .period_us (tone.period_us),
    .on_ms     (tone.on_ms),
    .off_ms    (tone.off_ms)
  );

endmodule

`default_nettype wire
